>>> sv/ubx_nav_solution_parser_assert.svh
// Assertion macros shared by the UBX parser checker.
`ifndef UBX_NAV_SOLUTION_PARSER_ASSERT_SVH
`define UBX_NAV_SOLUTION_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define UBX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define UBX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ubx_pkg.sv
// Package: UBX parser types, framing codes and message layout constants.
package ubx_pkg;

  // Payload buffer size of the original receiver; longer frames are rejected
  localparam int unsigned PAYLOAD_BYTES = 64;

  // Only the first bytes of a payload are ever decoded
  localparam int unsigned STG_BYTES = 36;
  localparam int unsigned STG_IW    = $clog2(STG_BYTES);

  // Framing bytes and message codes
  localparam logic [7:0] SYNC_1     = 8'hB5;
  localparam logic [7:0] SYNC_2     = 8'h62;
  localparam logic [7:0] CLS_NAV    = 8'h01;
  localparam logic [7:0] ID_POSLLH  = 8'h02;
  localparam logic [7:0] ID_STATUS  = 8'h03;
  localparam logic [7:0] ID_VELNED  = 8'h12;

  // Minimum payload length for each decoded message
  localparam logic [15:0] LEN_POSLLH = 16'd28;
  localparam logic [15:0] LEN_VELNED = 16'd36;
  localparam logic [15:0] LEN_STATUS = 16'd16;

  // Frame parser phases
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_t;

  // One payload byte to be kept for decoding
  typedef struct packed {
    logic              we;
    logic [STG_IW-1:0] idx;
    logic [7:0]        data;
  } stg_wr_t;

  // End of a good class-1 frame
  typedef struct packed {
    logic        done;
    logic [7:0]  id;
    logic [15:0] len;
  } frm_evt_t;

endpackage

>>> sv/ubx_nav_solution_parser.sv
// Top level: UBX navigation solution parser with input and result registers.
//
//   channel  direction  handshake              payload
//   in_      to block   in_valid / in_stall    in_rx_byte
//   out_     from block out_valid / out_stall  out_byte_taken, out_solution_ready, nav fields
//
// One byte per clock unless stalled; a byte passes the input, then the result register.
// The rate is set by the one combinational pass between input and result registers.
// The nav fields are the solution registers themselves and change only as a result loads.
// rst_n is synchronous: parser back to the first sync state, solution registers zeroed.
// A stalled result holds the input register, and in_stall rises only then.
module ubx_nav_solution_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_byte_taken,
  output logic        out_solution_ready,
  output logic [31:0] out_tow_ms,
  output logic signed [31:0] out_lat_e7,
  output logic signed [31:0] out_lon_e7,
  output logic [31:0] out_horiz_acc_mm,
  output logic [31:0] out_speed_cm_s,
  output logic signed [31:0] out_heading_e5,
  output logic [31:0] out_speed_acc_cm_s,
  output logic [31:0] out_heading_acc_e5,
  output logic [7:0]  out_fix_type_out,
  output logic        out_fix_ok_out
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic       taken_r, ready_r;
  logic       adv;
  logic       proc_en;
  logic       in_acc;
  logic       taken;
  logic       publish;

  ubx_pkg::stg_wr_t  stg_wr;
  ubx_pkg::frm_evt_t frm_evt;

  logic [31:0] lon_w, lat_w, course_w;

  // Handshake: the held byte moves on whenever the result slot is free or being taken
  assign adv      = !out_valid_r || !out_stall;
  assign proc_en  = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = proc_en ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  ubx_frm u_frm (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc_en (proc_en),
    .rx_byte (s1_byte_r),
    .taken   (taken),
    .stg_wr  (stg_wr),
    .frm_evt (frm_evt)
  );

  ubx_nav u_nav (
    .clk        (clk),
    .rst_n      (rst_n),
    .stg_wr     (stg_wr),
    .frm_evt    (frm_evt),
    .publish    (publish),
    .pub_tow_r  (out_tow_ms),
    .lon_r      (lon_w),
    .lat_r      (lat_w),
    .hacc_r     (out_horiz_acc_mm),
    .gspeed_r   (out_speed_cm_s),
    .course_r   (course_w),
    .sacc_r     (out_speed_acc_cm_s),
    .cacc_r     (out_heading_acc_e5),
    .fix_type_r (out_fix_type_out),
    .fix_ok_r   (out_fix_ok_out)
  );

  // Result register for the per-item flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      taken_r <= taken;
      ready_r <= publish;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_taken     = taken_r;
  assign out_solution_ready = ready_r;
  assign out_lat_e7         = signed'(lat_w);
  assign out_lon_e7         = signed'(lon_w);
  assign out_heading_e5     = signed'(course_w);

endmodule

>>> sv/ubx_frm.sv
// UBX framer: sync, header, length, payload capture and Fletcher checksum.
module ubx_frm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc_en,
  input  logic [7:0]        rx_byte,
  output logic              taken,
  output ubx_pkg::stg_wr_t  stg_wr,
  output ubx_pkg::frm_evt_t frm_evt
);

  ubx_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  got_a_r, got_a_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;

  // Running checksum with this item folded in
  assign add_a    = sum_a_r + rx_byte;
  assign add_b    = sum_b_r + add_a;
  assign cnt_inc  = cnt_r + 16'd1;
  assign len_full = {rx_byte, len_r[7:0]};

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ubx_pkg::PH_SYNC1;
      class_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      got_a_r <= '0;
    end else if (proc_en) begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      got_a_r <= got_a_nxt;
    end
  end

  // Next state and per-item outputs
  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    got_a_nxt = got_a_r;
    taken     = 1'b1;
    stg_wr    = '{we: 1'b0, idx: cnt_r[ubx_pkg::STG_IW-1:0], data: rx_byte};
    frm_evt   = '{done: 1'b0, id: id_r, len: len_r};

    case (phase_r)
      ubx_pkg::PH_SYNC2: begin
        if (rx_byte == ubx_pkg::SYNC_2) begin
          phase_nxt = ubx_pkg::PH_CLASS;
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end else begin
          phase_nxt = ubx_pkg::PH_SYNC1;
        end
      end
      ubx_pkg::PH_CLASS: begin
        class_nxt = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = ubx_pkg::PH_ID;
      end
      ubx_pkg::PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = ubx_pkg::PH_LEN1;
      end
      ubx_pkg::PH_LEN1: begin
        len_nxt   = {8'h00, rx_byte};
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = ubx_pkg::PH_LEN2;
      end
      ubx_pkg::PH_LEN2: begin
        len_nxt   = len_full;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        cnt_nxt   = '0;
        phase_nxt = (len_full == 16'd0) ? ubx_pkg::PH_CKA : ubx_pkg::PH_PAYLOAD;
      end
      ubx_pkg::PH_PAYLOAD: begin
        // only the leading bytes are ever decoded, so only those are kept
        stg_wr.we = proc_en && (cnt_r < 16'(ubx_pkg::STG_BYTES));
        cnt_nxt   = cnt_inc;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        if (cnt_inc >= len_r) begin
          phase_nxt = ubx_pkg::PH_CKA;
        end
      end
      ubx_pkg::PH_CKA: begin
        got_a_nxt = rx_byte;
        phase_nxt = ubx_pkg::PH_CKB;
      end
      ubx_pkg::PH_CKB: begin
        // the frame ends only when the held byte is really processed
        frm_evt.done = proc_en && (got_a_r == sum_a_r) && (rx_byte == sum_b_r) &&
                       (len_r <= 16'(ubx_pkg::PAYLOAD_BYTES)) &&
                       (class_r == ubx_pkg::CLS_NAV);
        phase_nxt = ubx_pkg::PH_SYNC1;
      end
      default: begin
        // hunting for the first sync byte; anything else is flagged as not taken
        if (rx_byte == ubx_pkg::SYNC_1) begin
          phase_nxt = ubx_pkg::PH_SYNC2;
        end else begin
          phase_nxt = ubx_pkg::PH_SYNC1;
          taken     = 1'b0;
        end
      end
    endcase
  end

endmodule

>>> sv/ubx_nav.sv
// UBX navigation decode: payload staging, solution registers and publish test.
module ubx_nav (
  input  logic              clk,
  input  logic              rst_n,
  input  ubx_pkg::stg_wr_t  stg_wr,
  input  ubx_pkg::frm_evt_t frm_evt,
  output logic              publish,
  output logic [31:0]       pub_tow_r,
  output logic [31:0]       lon_r,
  output logic [31:0]       lat_r,
  output logic [31:0]       hacc_r,
  output logic [31:0]       gspeed_r,
  output logic [31:0]       course_r,
  output logic [31:0]       sacc_r,
  output logic [31:0]       cacc_r,
  output logic [7:0]        fix_type_r,
  output logic              fix_ok_r
);

  logic [7:0] stg_r [ubx_pkg::STG_BYTES];

  logic [31:0] pos_tow_r, pos_tow_nxt;
  logic [31:0] vel_tow_r, vel_tow_nxt;
  logic [31:0] stat_tow_r, stat_tow_nxt;
  logic [31:0] pub_tow_nxt;
  logic [31:0] lon_nxt, lat_nxt, hacc_nxt;
  logic [31:0] gspeed_nxt, course_nxt, sacc_nxt, cacc_nxt;
  logic [7:0]  fix_type_nxt;
  logic        fix_ok_nxt;

  logic        is_pos, is_vel, is_stat;
  logic [31:0] w0, w4, w8, w20, w24, w28, w32;

  // Payload staging: one byte per item at the payload position
  always_ff @(posedge clk) begin
    if (stg_wr.we) begin
      stg_r[stg_wr.idx] <= stg_wr.data;
    end
  end

  // Little-endian words at the fixed message offsets
  assign w0  = {stg_r[3],  stg_r[2],  stg_r[1],  stg_r[0]};
  assign w4  = {stg_r[7],  stg_r[6],  stg_r[5],  stg_r[4]};
  assign w8  = {stg_r[11], stg_r[10], stg_r[9],  stg_r[8]};
  assign w20 = {stg_r[23], stg_r[22], stg_r[21], stg_r[20]};
  assign w24 = {stg_r[27], stg_r[26], stg_r[25], stg_r[24]};
  assign w28 = {stg_r[31], stg_r[30], stg_r[29], stg_r[28]};
  assign w32 = {stg_r[35], stg_r[34], stg_r[33], stg_r[32]};

  // Message type, gated by minimum length
  assign is_pos  = frm_evt.done && (frm_evt.id == ubx_pkg::ID_POSLLH) &&
                   (frm_evt.len >= ubx_pkg::LEN_POSLLH);
  assign is_vel  = frm_evt.done && (frm_evt.id == ubx_pkg::ID_VELNED) &&
                   (frm_evt.len >= ubx_pkg::LEN_VELNED);
  assign is_stat = frm_evt.done && (frm_evt.id == ubx_pkg::ID_STATUS) &&
                   (frm_evt.len >= ubx_pkg::LEN_STATUS);

  // Register updates and the coherence test on the updated times
  always_comb begin
    pos_tow_nxt  = is_pos  ? w0  : pos_tow_r;
    lon_nxt      = is_pos  ? w4  : lon_r;
    lat_nxt      = is_pos  ? w8  : lat_r;
    hacc_nxt     = is_pos  ? w20 : hacc_r;
    vel_tow_nxt  = is_vel  ? w0  : vel_tow_r;
    gspeed_nxt   = is_vel  ? w20 : gspeed_r;
    course_nxt   = is_vel  ? w24 : course_r;
    sacc_nxt     = is_vel  ? w28 : sacc_r;
    cacc_nxt     = is_vel  ? w32 : cacc_r;
    stat_tow_nxt = is_stat ? w0  : stat_tow_r;
    fix_type_nxt = is_stat ? stg_r[4] : fix_type_r;
    fix_ok_nxt   = is_stat ? stg_r[5][0] : fix_ok_r;

    // any good class-1 frame runs the test, even an unknown id
    publish = frm_evt.done && (pos_tow_nxt == vel_tow_nxt) &&
              (pos_tow_nxt == stat_tow_nxt) && (pos_tow_nxt != pub_tow_r);
    pub_tow_nxt = publish ? pos_tow_nxt : pub_tow_r;
  end

  // Solution registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_tow_r  <= '0;
      vel_tow_r  <= '0;
      stat_tow_r <= '0;
      pub_tow_r  <= '0;
      lon_r      <= '0;
      lat_r      <= '0;
      hacc_r     <= '0;
      gspeed_r   <= '0;
      course_r   <= '0;
      sacc_r     <= '0;
      cacc_r     <= '0;
      fix_type_r <= '0;
      fix_ok_r   <= 1'b0;
    end else begin
      pos_tow_r  <= pos_tow_nxt;
      vel_tow_r  <= vel_tow_nxt;
      stat_tow_r <= stat_tow_nxt;
      pub_tow_r  <= pub_tow_nxt;
      lon_r      <= lon_nxt;
      lat_r      <= lat_nxt;
      hacc_r     <= hacc_nxt;
      gspeed_r   <= gspeed_nxt;
      course_r   <= course_nxt;
      sacc_r     <= sacc_nxt;
      cacc_r     <= cacc_nxt;
      fix_type_r <= fix_type_nxt;
      fix_ok_r   <= fix_ok_nxt;
    end
  end

endmodule

>>> sv/ubx_chk.sv
// Port-level checker for the UBX parser, bound to the top level.
`include "ubx_nav_solution_parser_assert.svh"

module ubx_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_byte_taken,
  input logic        out_solution_ready,
  input logic [31:0] out_tow_ms
);

  // A stalled result stays offered and keeps its flag
  `UBX_ASSERT_NEXT(a_hold_vld, out_valid && out_stall, out_valid, "valid dropped")
  `UBX_ASSERT_NEXT(a_hold_flag, out_valid && out_stall, $stable(out_byte_taken), "flag moved")

  // The input side only backs up behind a stalled result
  `UBX_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "stall without cause")

  // A published solution always ends a UBX frame
  `UBX_ASSERT_NOW(a_ready_taken, out_valid && out_solution_ready, out_byte_taken, "refused byte")

  // The published time only moves together with a ready pulse
  `UBX_ASSERT_NOW(a_tow_pub, !$stable(out_tow_ms), out_solution_ready, "unpublished tow")

endmodule

bind ubx_nav_solution_parser ubx_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_byte_taken     (out_byte_taken),
  .out_solution_ready (out_solution_ready),
  .out_tow_ms         (out_tow_ms)
);

>>> test/ubx_nav_solution_parser_test.sv
// Self-checking testbench for the UBX navigation solution parser: byte stream in, checked outputs.
`timescale 1ns / 100ps

module ubx_nav_solution_parser_test;

  typedef logic [7:0] byte_q_t[$];

  // One output item of the parser
  typedef struct {
    logic               taken;
    logic               ready;
    logic [31:0]        tow;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic [31:0]        hacc;
    logic [31:0]        speed;
    logic signed [31:0] heading;
    logic [31:0]        speed_acc;
    logic [31:0]        heading_acc;
    logic [7:0]         fix_type;
    logic               fix_ok;
  } nav_out_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_byte_taken;
  logic               out_solution_ready;
  logic [31:0]        out_tow_ms;
  logic signed [31:0] out_lat_e7;
  logic signed [31:0] out_lon_e7;
  logic [31:0]        out_horiz_acc_mm;
  logic [31:0]        out_speed_cm_s;
  logic signed [31:0] out_heading_e5;
  logic [31:0]        out_speed_acc_cm_s;
  logic [31:0]        out_heading_acc_e5;
  logic [7:0]         out_fix_type_out;
  logic               out_fix_ok_out;

  // Bytes still to send, outputs still to arrive
  logic [7:0]  rx_stream_q[$];
  nav_out_t    nav_out_q[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_sent = 0;
  int unsigned outputs_seen = 0;
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic [31:0] last_epoch_tow = '0;

  // Shadow copy of the parser state
  ubx_pkg::phase_t sh_phase = ubx_pkg::PH_SYNC1;
  logic [7:0]  sh_class = '0;
  logic [7:0]  sh_id = '0;
  logic [15:0] sh_len = '0;
  logic [15:0] sh_count = '0;
  logic [7:0]  sh_sum_a = '0;
  logic [7:0]  sh_sum_b = '0;
  logic [7:0]  sh_got_sum_a = '0;
  logic [7:0]  sh_store [ubx_pkg::PAYLOAD_BYTES];
  logic [31:0] sh_lon = '0;
  logic [31:0] sh_lat = '0;
  logic [31:0] sh_hacc = '0;
  logic [31:0] sh_speed = '0;
  logic [31:0] sh_course = '0;
  logic [31:0] sh_speed_acc = '0;
  logic [31:0] sh_course_acc = '0;
  logic [7:0]  sh_fix_type = '0;
  logic        sh_fix_ok = 1'b0;
  logic [31:0] sh_pos_tow = '0;
  logic [31:0] sh_vel_tow = '0;
  logic [31:0] sh_stat_tow = '0;
  logic [31:0] sh_pub_tow = '0;

  ubx_nav_solution_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_taken     (out_byte_taken),
    .out_solution_ready (out_solution_ready),
    .out_tow_ms         (out_tow_ms),
    .out_lat_e7         (out_lat_e7),
    .out_lon_e7         (out_lon_e7),
    .out_horiz_acc_mm   (out_horiz_acc_mm),
    .out_speed_cm_s     (out_speed_cm_s),
    .out_heading_e5     (out_heading_e5),
    .out_speed_acc_cm_s (out_speed_acc_cm_s),
    .out_heading_acc_e5 (out_heading_acc_e5),
    .out_fix_type_out   (out_fix_type_out),
    .out_fix_ok_out     (out_fix_ok_out)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  // 8-bit Fletcher running sums
  function automatic void add_to_sum(logic [7:0] b);
    sh_sum_a = sh_sum_a + b;
    sh_sum_b = sh_sum_b + sh_sum_a;
  endfunction

  // Little-endian word from the payload store
  function automatic logic [31:0] stored_word(int unsigned pos);
    return {sh_store[pos + 3], sh_store[pos + 2], sh_store[pos + 1], sh_store[pos]};
  endfunction

  // Decode a good frame; returns 1 when a new solution gets published
  function automatic logic apply_frame();
    if (sh_class != ubx_pkg::CLS_NAV) return 1'b0;
    if (sh_id == ubx_pkg::ID_POSLLH && sh_len >= ubx_pkg::LEN_POSLLH) begin
      sh_pos_tow = stored_word(0);
      sh_lon     = stored_word(4);
      sh_lat     = stored_word(8);
      sh_hacc    = stored_word(20);
    end else if (sh_id == ubx_pkg::ID_VELNED && sh_len >= ubx_pkg::LEN_VELNED) begin
      sh_vel_tow    = stored_word(0);
      sh_speed      = stored_word(20);
      sh_course     = stored_word(24);
      sh_speed_acc  = stored_word(28);
      sh_course_acc = stored_word(32);
    end else if (sh_id == ubx_pkg::ID_STATUS && sh_len >= ubx_pkg::LEN_STATUS) begin
      sh_stat_tow = stored_word(0);
      sh_fix_type = sh_store[4];
      sh_fix_ok   = sh_store[5][0];
    end
    // publish only when all three agree on a time not yet published
    if (sh_pos_tow != sh_vel_tow || sh_pos_tow != sh_stat_tow || sh_pos_tow == sh_pub_tow)
      return 1'b0;
    sh_pub_tow = sh_pos_tow;
    return 1'b1;
  endfunction

  // Advance the shadow parser by one byte and give the output it causes
  function automatic nav_out_t parse_rx_byte(logic [7:0] b);
    nav_out_t r;
    r.taken = 1'b1;
    r.ready = 1'b0;
    case (sh_phase)
      ubx_pkg::PH_SYNC2: begin
        if (b == ubx_pkg::SYNC_2) begin
          sh_phase = ubx_pkg::PH_CLASS;
          sh_sum_a = '0;
          sh_sum_b = '0;
        end else begin
          sh_phase = ubx_pkg::PH_SYNC1;
        end
      end
      ubx_pkg::PH_CLASS: begin
        sh_class = b;
        add_to_sum(b);
        sh_phase = ubx_pkg::PH_ID;
      end
      ubx_pkg::PH_ID: begin
        sh_id = b;
        add_to_sum(b);
        sh_phase = ubx_pkg::PH_LEN1;
      end
      ubx_pkg::PH_LEN1: begin
        sh_len = {8'h00, b};
        add_to_sum(b);
        sh_phase = ubx_pkg::PH_LEN2;
      end
      ubx_pkg::PH_LEN2: begin
        sh_len[15:8] = b;
        add_to_sum(b);
        sh_count = '0;
        sh_phase = (sh_len == 16'd0) ? ubx_pkg::PH_CKA : ubx_pkg::PH_PAYLOAD;
      end
      ubx_pkg::PH_PAYLOAD: begin
        // bytes past the store are summed but dropped
        if (sh_count < ubx_pkg::PAYLOAD_BYTES) sh_store[sh_count] = b;
        sh_count = sh_count + 16'd1;
        add_to_sum(b);
        if (sh_count >= sh_len) sh_phase = ubx_pkg::PH_CKA;
      end
      ubx_pkg::PH_CKA: begin
        sh_got_sum_a = b;
        sh_phase = ubx_pkg::PH_CKB;
      end
      ubx_pkg::PH_CKB: begin
        if (sh_got_sum_a == sh_sum_a && b == sh_sum_b &&
            sh_len <= ubx_pkg::PAYLOAD_BYTES)
          r.ready = apply_frame();
        sh_phase = ubx_pkg::PH_SYNC1;
      end
      default: begin
        if (b == ubx_pkg::SYNC_1) begin
          sh_phase = ubx_pkg::PH_SYNC2;
        end else begin
          sh_phase = ubx_pkg::PH_SYNC1;
          r.taken = 1'b0;
        end
      end
    endcase
    r.tow         = sh_pub_tow;
    r.lat         = sh_lat;
    r.lon         = sh_lon;
    r.hacc        = sh_hacc;
    r.speed       = sh_speed;
    r.heading     = sh_course;
    r.speed_acc   = sh_speed_acc;
    r.heading_acc = sh_course_acc;
    r.fix_type    = sh_fix_type;
    r.fix_ok      = sh_fix_ok;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void send_byte(logic [7:0] b);
    rx_stream_q.push_back(b);
    bytes_queued++;
  endfunction

  // Whole frame: sync, header, first len bytes of body, checksum
  function automatic void send_frame(logic [7:0] cls, logic [7:0] id, logic [15:0] len,
                                     byte_q_t body, bit bad_sum);
    logic [7:0] a;
    logic [7:0] s;
    byte_q_t    framed;
    a = '0;
    s = '0;
    framed = {cls, id, len[7:0], len[15:8]};
    for (int i = 0; i < len; i++) framed.push_back(body[i]);
    send_byte(ubx_pkg::SYNC_1);
    send_byte(ubx_pkg::SYNC_2);
    foreach (framed[i]) begin
      a = a + framed[i];
      s = s + a;
      send_byte(framed[i]);
    end
    if (bad_sum) begin
      if ($urandom_range(0, 1)) a = a ^ (8'h01 << $urandom_range(0, 7));
      else s = s ^ (8'h01 << $urandom_range(0, 7));
    end
    send_byte(a);
    send_byte(s);
  endfunction

  // Payload with time of week up front; patterns hit the signed extremes
  function automatic byte_q_t make_body(int unsigned len, logic [31:0] tow);
    byte_q_t     body;
    int unsigned fill;
    fill = $urandom_range(0, 9);
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        0: body.push_back(8'h00);
        1: body.push_back(8'hFF);
        2: body.push_back((i % 4 == 3) ? 8'h80 : 8'h00);
        3: body.push_back((i % 4 == 3) ? 8'h7F : 8'hFF);
        default: body.push_back(8'($urandom));
      endcase
    end
    for (int unsigned i = 0; i < 4 && i < len; i++) body[i] = tow[8*i +: 8];
    return body;
  endfunction

  // Mostly the real message size, sometimes padded up to the store size
  function automatic logic [15:0] good_len(logic [15:0] min_len);
    case ($urandom_range(0, 7))
      0: return 16'(ubx_pkg::PAYLOAD_BYTES);
      1: return 16'(min_len + $urandom_range(1, ubx_pkg::PAYLOAD_BYTES - min_len));
      default: return min_len;
    endcase
  endfunction

  function automatic void send_nav_msg(int unsigned kind, logic [31:0] tow, bit bad_sum);
    logic [7:0]  id;
    logic [15:0] len;
    case (kind)
      0: begin
        id  = ubx_pkg::ID_POSLLH;
        len = good_len(ubx_pkg::LEN_POSLLH);
      end
      1: begin
        id  = ubx_pkg::ID_VELNED;
        len = good_len(ubx_pkg::LEN_VELNED);
      end
      default: begin
        id  = ubx_pkg::ID_STATUS;
        len = good_len(ubx_pkg::LEN_STATUS);
      end
    endcase
    send_frame(ubx_pkg::CLS_NAV, id, len, make_body(len, tow), bad_sum);
  endfunction

  // Position, velocity and status for one epoch, in a rotated, sometimes reversed order
  function automatic void send_epoch();
    logic [31:0] tow;
    int unsigned first;
    bit          reverse;
    case ($urandom_range(0, 19))
      0: tow = last_epoch_tow;   // same time again: nothing new to publish
      1: tow = '0;
      2: tow = '1;
      default: tow = $urandom;
    endcase
    last_epoch_tow = tow;
    first   = $urandom_range(0, 2);
    reverse = 1'($urandom_range(0, 1));
    for (int unsigned k = 0; k < 3; k++) begin
      int unsigned kind;
      kind = (first + (reverse ? 3 - k : k)) % 3;
      // now and then one message carries a stray time or a bad checksum
      send_nav_msg(kind, ($urandom_range(0, 9) == 0) ? $urandom : tow,
                   $urandom_range(0, 19) == 0);
    end
  endfunction

  // Frames that must leave the navigation registers alone
  function automatic void send_broken_frame();
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    cls = ubx_pkg::CLS_NAV;
    id  = ubx_pkg::ID_POSLLH;
    len = ubx_pkg::LEN_POSLLH;
    case ($urandom_range(0, 4))
      0: begin
        // foreign class
        cls = 8'($urandom);
        if (cls == ubx_pkg::CLS_NAV) cls = 8'hFF;
        id  = $urandom_range(0, 1) ? ubx_pkg::ID_POSLLH : 8'(($urandom));
        len = 16'($urandom_range(0, 40));
      end
      1: begin
        // unknown id in the nav class
        id = 8'($urandom);
        if (id == ubx_pkg::ID_POSLLH || id == ubx_pkg::ID_STATUS ||
            id == ubx_pkg::ID_VELNED) id = 8'h00;
        len = 16'($urandom_range(0, 40));
      end
      2: begin
        // known message, payload too short
        case ($urandom_range(0, 2))
          0: len = ubx_pkg::LEN_POSLLH;
          1: begin
            id  = ubx_pkg::ID_VELNED;
            len = ubx_pkg::LEN_VELNED;
          end
          default: begin
            id  = ubx_pkg::ID_STATUS;
            len = ubx_pkg::LEN_STATUS;
          end
        endcase
        len = 16'(len - $urandom_range(1, len));
      end
      3: begin
        // longer than the store
        id  = $urandom_range(0, 1) ? ubx_pkg::ID_STATUS : ubx_pkg::ID_VELNED;
        len = 16'(ubx_pkg::PAYLOAD_BYTES + $urandom_range(1, 30));
      end
      default: begin
        send_nav_msg($urandom_range(0, 2), $urandom, 1'b1);
        return;
      end
    endcase
    send_frame(cls, id, len, make_body(len, $urandom), 1'b0);
  endfunction

  // Line noise between frames
  function automatic void send_noise();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(1, 4);
    for (int unsigned i = 0; i < n; i++) begin
      b = 8'($urandom);
      // a trailing sync byte would swallow the next frame's own sync
      if (i == n - 1 && b == ubx_pkg::SYNC_1) b = 8'h00;
      send_byte(b);
    end
  endfunction

  function automatic void send_directed();
    byte_q_t none;
    // refused outside a frame: both extremes and a lone second sync
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ubx_pkg::SYNC_2);
    // bad second sync, then a repeated first sync
    send_byte(ubx_pkg::SYNC_1);
    send_byte(8'h00);
    send_byte(ubx_pkg::SYNC_1);
    send_byte(ubx_pkg::SYNC_1);
    // zero-length frames straight to the checksum
    send_frame(ubx_pkg::CLS_NAV, ubx_pkg::ID_POSLLH, 16'd0, none, 1'b0);
    send_frame(8'hFF, 8'hFF, 16'd0, none, 1'b1);
  endfunction

  function automatic void send_random_chunk();
    case ($urandom_range(0, 9))
      0: send_noise();
      1, 2: send_broken_frame();
      default: send_epoch();
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 200) $display("[%0t] output %0d: %s", $time, outputs_seen, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h, want %h", name, got, want));
  endtask

  task automatic check_output();
    nav_out_t want;
    outputs_seen++;
    if (nav_out_q.size() == 0) begin
      report_mismatch("output item with no byte waiting for it");
    end else begin
      want = nav_out_q.pop_front();
      check_field("byte_taken", out_byte_taken, want.taken);
      check_field("solution_ready", out_solution_ready, want.ready);
      check_field("tow_ms", out_tow_ms, want.tow);
      check_field("lat_e7", out_lat_e7, want.lat);
      check_field("lon_e7", out_lon_e7, want.lon);
      check_field("horiz_acc_mm", out_horiz_acc_mm, want.hacc);
      check_field("speed_cm_s", out_speed_cm_s, want.speed);
      check_field("heading_e5", out_heading_e5, want.heading);
      check_field("speed_acc_cm_s", out_speed_acc_cm_s, want.speed_acc);
      check_field("heading_acc_e5", out_heading_acc_e5, want.heading_acc);
      check_field("fix_type_out", out_fix_type_out, want.fix_type);
      check_field("fix_ok_out", out_fix_ok_out, want.fix_ok);
    end
  endtask

  // Driver: offers the next queued byte unless idling; a stalled item is held
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nav_out_q.push_back(parse_rx_byte(in_rx_byte));
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_stream_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted output item, stalls at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_output();
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Sequence: reset, then four phases of idling and stalling, each drained before the next
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      int unsigned phase_start;
      case (p)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          send_directed();
        end
        1: begin
          tx_idle_pct  = 73;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 73;
        end
        default: begin
          tx_idle_pct  = 33;
          rx_stall_pct = 33;
        end
      endcase
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 330) send_random_chunk();
      // sender holds off until every output has come back
      while (bytes_sent != bytes_queued || nav_out_q.size() != 0) @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
